### rtl/core/ppp_pkg.sv
// Shared constants and types for the perspective point projection block.
`timescale 1ns / 1ps
package ppp_pkg;

  localparam int QUO_W   = 41;
  localparam int NDC_LOG = 40;
  localparam int IDX_W   = 8;

  localparam logic [13:0] WIDTH_RST  = 14'd1920;
  localparam logic [13:0] HEIGHT_RST = 14'd1080;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X_FIRST  = 8'd0,
    REG_ROW_X_SECOND = 8'd1,
    REG_ROW_Y_FIRST  = 8'd2,
    REG_ROW_Y_SECOND = 8'd3,
    REG_ROW_W_FIRST  = 8'd4,
    REG_ROW_W_SECOND = 8'd5,
    REG_WIDTH        = 8'd6,
    REG_HEIGHT       = 8'd7
  } reg_idx_e;

endpackage

### rtl/core/ppp_if.sv
// Handshake channel interfaces for points, screen results and configuration.
`timescale 1ns / 1ps
interface ppp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_screen_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

interface ppp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/ppp_dot.sv
// Three-stage row dot product of a point with one matrix row.
`timescale 1ns / 1ps
module ppp_dot #(
  parameter int FRAC_BITS = 16,
  parameter int CW = 50
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [31:0]   x_i,
  input  logic signed [31:0]   y_i,
  input  logic signed [31:0]   z_i,
  input  logic [63:0]          first_i,
  input  logic [63:0]          second_i,
  output logic signed [CW-1:0] sum_o
);
  logic signed [31:0]   x_q, y_q, z_q, e3_q;
  logic signed [63:0]   p0_q, p1_q, p2_q;
  logic signed [63:0]   sum_d;
  logic signed [CW-1:0] sum_q;

  assign sum_d = (p0_q >>> FRAC_BITS) + (p1_q >>> FRAC_BITS) + (p2_q >>> FRAC_BITS)
               + 64'(e3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      p0_q  <= 64'(x_q) * 64'($signed(first_i[31:0]));
      p1_q  <= 64'(y_q) * 64'($signed(first_i[63:32]));
      p2_q  <= 64'(z_q) * 64'($signed(second_i[31:0]));
      e3_q  <= $signed(second_i[63:32]);
      sum_q <= sum_d[CW-1:0];
    end
  end

  assign sum_o = sum_q;
endmodule

### rtl/core/ppp_div.sv
// Pipelined restoring divider giving one quotient bit per stage.
`timescale 1ns / 1ps
module ppp_div
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int CW = 50
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] num_i,
  input  logic [CW-1:0]        den_i,
  output logic [QUO_W-1:0]     quo_o,
  output logic                 ovf_o,
  output logic                 neg_o
);
  localparam int WW = CW + QUO_W;

  logic [CW-1:0]    abs_d;
  logic [WW-1:0]    num_w, den_w;
  logic [CW-1:0]    a_q [QUO_W+1];
  logic [CW-1:0]    d_q [QUO_W+1];
  logic [CW-1:0]    r_q [QUO_W+1];
  logic [QUO_W-1:0] q_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic             neg_q [QUO_W+1];

  assign abs_d = num_i[CW-1] ? CW'(-num_i) : CW'(num_i);
  assign num_w = WW'(abs_d) << FRAC_BITS;
  assign den_w = WW'(den_i) << QUO_W;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]   <= abs_d;
      d_q[0]   <= den_i;
      r_q[0]   <= abs_d >> (QUO_W - FRAC_BITS);
      q_q[0]   <= '0;
      ovf_q[0] <= num_w >= den_w;
      neg_q[0] <= num_i[CW-1];
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int K = QUO_W - 1 - i;
    logic          bit_in;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          ge;

    if (K >= FRAC_BITS) begin : g_bit
      assign bit_in = a_q[i][K-FRAC_BITS];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {r_q[i], bit_in};
    assign diff  = trial - {1'b0, d_q[i]};
    assign ge    = trial >= {1'b0, d_q[i]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[i+1]   <= a_q[i];
        d_q[i+1]   <= d_q[i];
        ovf_q[i+1] <= ovf_q[i];
        neg_q[i+1] <= neg_q[i];
        r_q[i+1]   <= ge ? diff[CW-1:0] : trial[CW-1:0];
        q_q[i+1]   <= {q_q[i][QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = q_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];
  assign neg_o = neg_q[QUO_W];
endmodule

### rtl/core/ppp_screen.sv
// Viewport mapping: limit, sign, scale, offset and saturate over three stages.
`timescale 1ns / 1ps
module ppp_screen
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               vis_i,
  input  logic [QUO_W-1:0]   qx_i,
  input  logic               ovfx_i,
  input  logic               negx_i,
  input  logic [QUO_W-1:0]   qy_i,
  input  logic               ovfy_i,
  input  logic               negy_i,
  input  logic [12:0]        hw_i,
  input  logic [12:0]        hh_i,
  output logic               vis_o,
  output logic signed [31:0] sx_o,
  output logic signed [31:0] sy_o
);
  localparam int NW = QUO_W + 1;
  localparam int SW = QUO_W + 17;
  localparam logic [QUO_W-1:0] LIMIT = QUO_W'(1) << NDC_LOG;

  logic [QUO_W-1:0]     magx, magy;
  logic signed [NW-1:0] ndcx_d, ndcy_d, ndcx_q, ndcy_q;
  logic signed [14:0]   mx, my;
  logic signed [SW-1:0] px_q, py_q, sx_d, sy_d;
  logic                 vis1_q, vis2_q, vis_q;
  logic signed [31:0]   sx_q, sy_q;

  assign magx   = (ovfx_i || qx_i > LIMIT) ? LIMIT : qx_i;
  assign magy   = (ovfy_i || qy_i > LIMIT) ? LIMIT : qy_i;
  assign ndcx_d = negx_i ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
  assign ndcy_d = negy_i ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
  assign mx     = $signed({1'b0, 14'({1'b0, hw_i}) + 14'd1});
  assign my     = 15'sd1 - $signed({2'b00, hh_i});
  assign sx_d   = px_q + (SW'(hw_i) << FRAC_BITS);
  assign sy_d   = py_q + (SW'(hh_i) << FRAC_BITS);

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic hi_same;
    hi_same = (v[SW-1:31] == '0) || (v[SW-1:31] == '1);
    if (hi_same) return v[31:0];
    return v[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ndcx_q <= ndcx_d;
      ndcy_q <= ndcy_d;
      vis1_q <= vis_i;
      px_q   <= SW'(ndcx_q) * SW'(mx);
      py_q   <= SW'(ndcy_q) * SW'(my);
      vis2_q <= vis1_q;
      vis_q  <= vis2_q;
      sx_q   <= vis2_q ? sat32(sx_d) : '0;
      sy_q   <= vis2_q ? sat32(sy_d) : '0;
    end
  end

  assign vis_o = vis_q;
  assign sx_o  = sx_q;
  assign sy_o  = sy_q;
endmodule

### rtl/core/perspective_point_projection.sv
// Path from an accepted point to its result: 3 + 41 + 1 + 3 stages.
// Throughput: one point per cycle when not stalled; one quotient bit per divider step.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits, zeroes the matrix and sets the viewport to 1920 by 1080.
// Configuration is accepted in every cycle.
`timescale 1ns / 1ps
module perspective_point_projection
  import ppp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ppp_point_if.sink     point_i,
  ppp_screen_if.source  screen_o,
  ppp_cfg_if.sink       cfg_i
);
  localparam int CW  = 66 - FRAC_BITS;
  localparam int NST = 7 + QUO_W;
  localparam logic signed [CW-1:0] THR = CW'(((1 << FRAC_BITS) + 5) / 10);

  logic [63:0] rxf_q, rxs_q, ryf_q, rys_q, rwf_q, rws_q;
  logic [13:0] width_q, height_q;
  logic [NST-1:0] vld_q;
  logic           vis_q [QUO_W+1];
  logic           en;
  logic signed [CW-1:0] cx, cy, cw;
  logic                 vis_c;
  logic [CW-1:0]        den;
  logic [QUO_W-1:0]     qx, qy;
  logic                 ovfx, ovfy, negx, negy;

  assign en            = !vld_q[NST-1] || screen_o.ready;
  assign point_i.ready = en;
  assign cfg_i.ready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rxf_q    <= '0;
      rxs_q    <= '0;
      ryf_q    <= '0;
      rys_q    <= '0;
      rwf_q    <= '0;
      rws_q    <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_ROW_X_FIRST:  rxf_q    <= cfg_i.data;
        REG_ROW_X_SECOND: rxs_q    <= cfg_i.data;
        REG_ROW_Y_FIRST:  ryf_q    <= cfg_i.data;
        REG_ROW_Y_SECOND: rys_q    <= cfg_i.data;
        REG_ROW_W_FIRST:  rwf_q    <= cfg_i.data;
        REG_ROW_W_SECOND: rws_q    <= cfg_i.data;
        REG_WIDTH:        width_q  <= cfg_i.data[13:0];
        REG_HEIGHT:       height_q <= cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], point_i.valid};
    end
  end

  ppp_dot #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_dot_x (
    .clk_i, .en_i(en), .x_i(point_i.point_x), .y_i(point_i.point_y),
    .z_i(point_i.point_z), .first_i(rxf_q), .second_i(rxs_q), .sum_o(cx)
  );
  ppp_dot #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_dot_y (
    .clk_i, .en_i(en), .x_i(point_i.point_x), .y_i(point_i.point_y),
    .z_i(point_i.point_z), .first_i(ryf_q), .second_i(rys_q), .sum_o(cy)
  );
  ppp_dot #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_dot_w (
    .clk_i, .en_i(en), .x_i(point_i.point_x), .y_i(point_i.point_y),
    .z_i(point_i.point_z), .first_i(rwf_q), .second_i(rws_q), .sum_o(cw)
  );

  assign vis_c = cw >= THR;
  assign den   = vis_c ? CW'(cw) : CW'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q[0] <= vis_c;
      for (int i = 1; i <= QUO_W; i++) begin
        vis_q[i] <= vis_q[i-1];
      end
    end
  end

  ppp_div #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_div_x (
    .clk_i, .en_i(en), .num_i(cx), .den_i(den), .quo_o(qx), .ovf_o(ovfx), .neg_o(negx)
  );
  ppp_div #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_div_y (
    .clk_i, .en_i(en), .num_i(cy), .den_i(den), .quo_o(qy), .ovf_o(ovfy), .neg_o(negy)
  );

  ppp_screen #(.FRAC_BITS(FRAC_BITS)) u_screen (
    .clk_i, .en_i(en), .vis_i(vis_q[QUO_W]),
    .qx_i(qx), .ovfx_i(ovfx), .negx_i(negx),
    .qy_i(qy), .ovfy_i(ovfy), .negy_i(negy),
    .hw_i(width_q[13:1]), .hh_i(height_q[13:1]),
    .vis_o(screen_o.visible), .sx_o(screen_o.screen_x), .sy_o(screen_o.screen_y)
  );

  assign screen_o.valid = vld_q[NST-1];

  a_zero_when_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    screen_o.valid && !screen_o.visible |-> screen_o.screen_x == 0 && screen_o.screen_y == 0)
    else $error("hidden point with nonzero screen position");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.valid && point_i.ready |=> vld_q[0])
    else $error("accepted item missing from first stage");
endmodule

### verif/perspective_point_projection_tb.sv
// Self-checking testbench for the perspective point projection block.
`timescale 1ns / 1ps
module perspective_point_projection_tb;
  import ppp_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 48;
  localparam int STALL_LIMIT = 20000;
  localparam longint NDC_MAX = 64'sd1 << 40;

  typedef struct packed {
    logic        visible;
    logic [31:0] sx;
    logic [31:0] sy;
  } screen_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          known;
    screen_t     want;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppp_point_if  pnt();
  ppp_screen_if scr();
  ppp_cfg_if    cfg();

  perspective_point_projection dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pnt.sink),
    .screen_o (scr.source),
    .cfg_i    (cfg.sink)
  );

  always #10 clk_i = ~clk_i;

  logic [63:0] matrix_regs [6];
  logic [13:0] view_w, view_h;
  screen_t     pending_screens [$];
  int          errors = 0;
  int          idle_count = 0;
  bit          calm = 1'b0;
  bit          hold_sink = 1'b0;
  int          hold_cycles = 0;

  function automatic longint floor_q(longint p);
    return p >>> FRAC;
  endfunction

  function automatic longint project_row(logic [63:0] a, logic [63:0] b,
                                         longint x, longint y, longint z);
    longint e0, e1, e2, e3;
    e0 = longint'(signed'(a[31:0]));
    e1 = longint'(signed'(a[63:32]));
    e2 = longint'(signed'(b[31:0]));
    e3 = longint'(signed'(b[63:32]));
    return floor_q(x * e0) + floor_q(y * e1) + floor_q(z * e2) + e3;
  endfunction

  function automatic longint ndc_div(longint n, longint d);
    longint unsigned a, ud, q, r;
    a = n < 0 ? 64'(-n) : 64'(n);
    ud = 64'(d);
    q = a / ud;
    r = a % ud;
    if (q > 64'(NDC_MAX >>> FRAC)) q = 64'(NDC_MAX);
    else begin
      for (int i = 0; i < FRAC; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 64'd1;
        end
      end
      if (q > 64'(NDC_MAX)) q = 64'(NDC_MAX);
    end
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic screen_t predict_screen(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz);
    longint x, y, z, cx, cy, cw, nx, ny, hw, hh;
    screen_t r;
    x = longint'(signed'(px));
    y = longint'(signed'(py));
    z = longint'(signed'(pz));
    cx = project_row(matrix_regs[0], matrix_regs[1], x, y, z);
    cy = project_row(matrix_regs[2], matrix_regs[3], x, y, z);
    cw = project_row(matrix_regs[4], matrix_regs[5], x, y, z);
    r = '0;
    if (cw < ((64'sd1 << FRAC) + 5) / 10) return r;
    nx = ndc_div(cx, cw);
    ny = ndc_div(cy, cw);
    hw = longint'(view_w >> 1);
    hh = longint'(view_h >> 1);
    r.visible = 1'b1;
    r.sx = clamp32(nx * (hw + 1) + (hw <<< FRAC));
    r.sy = clamp32(ny * (1 - hh) + (hh <<< FRAC));
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_WIDTH:  view_w = value[13:0];
      REG_HEIGHT: view_h = value[13:0];
      default:    matrix_regs[idx] = value;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    pnt.valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit known, screen_t want);
    screen_t p;
    while (!calm && $urandom_range(99) < 13) begin
      pnt.valid <= 1'b0;
      @(posedge clk_i);
    end
    pnt.valid   <= 1'b1;
    pnt.point_x <= px;
    pnt.point_y <= py;
    pnt.point_z <= pz;
    p = predict_screen(px, py, pz);
    if (known && p !== want) begin
      errors++;
      $display("%0t predictor disagrees with table: expected %h actual %h", $time, want, p);
    end
    pending_screens.push_back(p);
    do @(posedge clk_i); while (!pnt.ready);
  endtask

  function automatic logic [63:0] rand_pair(int span);
    logic [31:0] a, b;
    a = 32'($urandom_range(2 * span)) - 32'(span);
    b = 32'($urandom_range(2 * span)) - 32'(span);
    return {b, a};
  endfunction

  task automatic random_matrix();
    write_reg(REG_ROW_X_FIRST, rand_pair(1 << 17));
    write_reg(REG_ROW_X_SECOND, {$urandom, $urandom});
    write_reg(REG_ROW_Y_FIRST, rand_pair(1 << 17));
    write_reg(REG_ROW_Y_SECOND, {$urandom, $urandom});
    write_reg(REG_ROW_W_FIRST, rand_pair(1 << 15));
    write_reg(REG_ROW_W_SECOND,
              {32'($urandom_range(1 << 20)) - 32'(1 << 16), 32'($urandom_range(1 << 16))});
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      scr.ready <= 1'b0;
    end else begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      scr.ready <= !(hold_sink || hold_cycles > 1) && (calm || $urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    screen_t got, want;
    if (rst_ni && scr.valid && scr.ready) begin
      got = {scr.visible, scr.screen_x, scr.screen_y};
      if (pending_screens.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h", $time, got);
      end else begin
        want = pending_screens.pop_front();
        if (got.visible !== want.visible) begin
          errors++;
          $display("%0t visible: expected %b actual %b", $time, want.visible, got.visible);
        end
        if (got.sx !== want.sx) begin
          errors++;
          $display("%0t screen_x: expected %h actual %h", $time, want.sx, got.sx);
        end
        if (got.sy !== want.sy) begin
          errors++;
          $display("%0t screen_y: expected %h actual %h", $time, want.sy, got.sy);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pnt.valid && pnt.ready) || (scr.valid && scr.ready) || (cfg.valid && cfg.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  point_row_t directed [$];

  initial begin
    screen_t zero_res;
    pnt.valid = 1'b0; pnt.point_x = '0; pnt.point_y = '0; pnt.point_z = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    scr.ready = 1'b0;
    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    view_w = WIDTH_RST;
    view_h = HEIGHT_RST;
    zero_res = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the matrix is zero, so every point is hidden.
    directed.push_back('{32'h0, 32'h0, 32'h0, 1'b1, zero_res});
    directed.push_back('{32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1, zero_res});
    directed.push_back('{32'h80000000, 32'h7fffffff, 32'h00010000, 1'b1, zero_res});
    foreach (directed[i])
      send_point(directed[i].px, directed[i].py, directed[i].pz, directed[i].known,
                 directed[i].want);
    drain_results();

    // Identity-like rows with w = z; exercises threshold, extremes, and saturation.
    write_reg(REG_ROW_X_FIRST, {32'h0, 32'h00010000});
    write_reg(REG_ROW_X_SECOND, 64'h0);
    write_reg(REG_ROW_Y_FIRST, {32'h00010000, 32'h0});
    write_reg(REG_ROW_Y_SECOND, 64'h0);
    write_reg(REG_ROW_W_FIRST, 64'h0);
    write_reg(REG_ROW_W_SECOND, {32'h0, 32'h00010000});
    directed.delete();
    directed.push_back('{32'h0, 32'h0, 32'd6553, 1'b1, zero_res});
    directed.push_back('{32'h0, 32'h0, 32'd6554, 1'b0, zero_res});
    directed.push_back('{32'h0, 32'h0, 32'h00010000, 1'b1, '{1'b1, 32'd960 << 16, 32'd540 << 16}});
    directed.push_back('{32'h7fffffff, 32'h80000000, 32'd6554, 1'b0, zero_res});
    directed.push_back('{32'h80000000, 32'h7fffffff, 32'd6554, 1'b0, zero_res});
    directed.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, zero_res});
    directed.push_back('{32'hffff0000, 32'h00010000, 32'h00020000, 1'b0, zero_res});
    directed.push_back('{32'h0, 32'h0, 32'h80000000, 1'b1, zero_res});
    directed.push_back('{32'h0, 32'h0, 32'hffffffff, 1'b1, zero_res});
    foreach (directed[i])
      send_point(directed[i].px, directed[i].py, directed[i].pz, directed[i].known,
                 directed[i].want);
    drain_results();

    // Viewport extremes: zero, one, full range, and a width that wraps in 14 bits.
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd1);
    send_point(32'h00008000, 32'hffff8000, 32'h00010000, 1'b0, zero_res);
    drain_results();
    write_reg(REG_WIDTH, 64'd8192);
    write_reg(REG_HEIGHT, 64'd8192);
    send_point(32'h7fff0000, 32'h80010000, 32'h00010000, 1'b0, zero_res);
    send_point(32'h00010000, 32'h00010000, 32'h00001999, 1'b0, zero_res);
    drain_results();
    write_reg(REG_WIDTH, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_HEIGHT, 64'd16383);
    send_point(32'h00010000, 32'hffff0000, 32'h00020000, 1'b0, zero_res);
    drain_results();

    // Random phases with new matrices and viewports.
    for (int phase = 0; phase < 10; phase++) begin
      random_matrix();
      write_reg(REG_WIDTH, 64'($urandom_range(8192, 1)));
      write_reg(REG_HEIGHT, 64'($urandom_range(8192, 1)));
      calm = (phase == 3);
      if (phase == 5) begin
        hold_cycles = 300;
        hold_sink = 1'b0;
      end
      for (int n = 0; n < 85; n++) begin
        case ($urandom_range(3))
          0: send_point($urandom, $urandom, $urandom, 1'b0, zero_res);
          default: send_point(32'($urandom_range(1 << 22)) - 32'(1 << 21),
                              32'($urandom_range(1 << 22)) - 32'(1 << 21),
                              32'($urandom_range(1 << 22)) - 32'(1 << 20), 1'b0, zero_res);
        endcase
        if (n == 40) begin
          pnt.valid <= 1'b0;
          while (pending_screens.size() != 0) @(posedge clk_i);
        end
      end
      calm = 1'b0;
      drain_results();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
